[sv/wst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_pkg
// Shared constants and types for the working set tracker.
// ----------------------------------------------------------------------------
package wst_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int SET_COUNT   = 512;
    localparam int WAYS        = 16;

    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int SET_W   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int SET_B   = $clog2(SET_COUNT);
    localparam int TAG_W   = 32 - OFF_W - SET_B;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int OCC_W   = $clog2(WAYS + 1);
    localparam int ENT_W   = SET_W + WAY_W;
    localparam int ENTRIES = SET_COUNT * (2 ** WAY_W);

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_INSTR = 2'd2;
    localparam logic [1:0] OP_LOOP  = 2'd3;

    localparam logic [1:0] MODE_BEST  = 2'd0;
    localparam logic [1:0] MODE_WORST = 2'd1;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // Request from the sequencer to the compare unit
    typedef struct packed {
        logic             start;
        logic [TAG_W-1:0] tag;
        logic [OCC_W-1:0] occ;
    } wst_scan_req_t;

    // Result of a way scan
    typedef struct packed {
        logic             done;
        logic             found;
        logic [WAY_W-1:0] way;
    } wst_scan_rsp_t;

endpackage

[sv/wst_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module wst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[sv/wst_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_scan
// Way scanner: walks the ways of one set through the tag RAM, one per cycle.
// ----------------------------------------------------------------------------
module wst_scan (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wst_pkg::wst_scan_req_t       req,
    input  logic [wst_pkg::TAG_W-1:0]    tag_rdata,
    output logic [wst_pkg::WAY_W-1:0]    rd_way,
    output wst_pkg::wst_scan_rsp_t       rsp
);
    import wst_pkg::*;

    logic             busy_reg, busy_next;
    logic             chk_reg, chk_next;
    logic [OCC_W-1:0] idx_reg, idx_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             hit;

    assign hit    = chk_reg && (tag_rdata == tag_reg);
    assign rd_way = idx_reg[WAY_W-1:0];

    // Issue one read per cycle, compare the previous one
    always_comb begin
        busy_next = busy_reg;
        chk_next  = 1'b0;
        idx_next  = idx_reg;
        tag_next  = tag_reg;
        occ_next  = occ_reg;
        rsp       = '0;
        if (req.start) begin
            busy_next = 1'b1;
            idx_next  = '0;
            tag_next  = req.tag;
            occ_next  = req.occ;
        end else if (busy_reg) begin
            if (hit) begin
                busy_next = 1'b0;
                rsp.done  = 1'b1;
                rsp.found = 1'b1;
                rsp.way   = WAY_W'(idx_reg - OCC_W'(1));
            end else if (idx_reg >= occ_reg) begin
                busy_next = 1'b0;
                rsp.done  = 1'b1;
            end else begin
                chk_next = 1'b1;
                idx_next = idx_reg + OCC_W'(1);
            end
        end
    end

    // Hold scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            chk_reg  <= chk_next;
            idx_reg  <= idx_next;
        end
        tag_reg <= tag_next;
        occ_reg <= occ_next;
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !busy_reg) else $error("scan still busy after done");
    a_found_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.found |-> chk_reg) else $error("hit without a compare");
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg <= occ_reg) else $error("scan index past occupancy");
`endif
endmodule

[sv/working_set_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// working_set_tracker
// Counts the working set of a memory access stream and folds per-loop counts.
// ----------------------------------------------------------------------------
// A read or write reads occupancy, scans the ways, writes the counters (a stored
//   block reads them first) and counts the access per loop; an unstorable block
//   skips the counters. An instruction or ignored item goes straight to output;
//   a loop boundary first folds the per-loop counts once tracking is on. One
//   item at a time; a waiting result holds the next one. The scan reads one tag
//   per cycle from the tag RAM. After reset the block clears the whole
//   occupancy RAM, accepting no item; all counters start at zero, mode at 1.
module working_set_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_new_block,
    output logic        m_set_full,
    output logic [13:0] m_distinct_blocks,
    output logic [4:0]  m_max_ways_used,
    output logic [31:0] m_loop_instructions,
    output logic [31:0] m_loop_reads,
    output logic [31:0] m_loop_writes,
    output logic [31:0] m_loop_accesses,
    output logic [31:0] m_total_reads,
    output logic [31:0] m_total_writes
);
    import wst_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_OCC   = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_RDCNT = 4'd4;
    localparam logic [3:0] ST_WRCNT = 4'd5;
    localparam logic [3:0] ST_FOLD  = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;
    localparam logic [3:0] ST_OCCWT = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       mode_reg;
    logic [1:0]       op_reg, op_next;
    logic [SET_W-1:0] set_reg, set_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [WAY_W-1:0] way_reg, way_next;
    logic [1:0]       k_reg, k_next;
    logic             newb_reg, newb_next, full_reg, full_next;
    logic             on_reg, on_next;
    logic [13:0]      blk_reg, blk_next;
    logic [OCC_W-1:0] wide_reg, wide_next;
    logic [31:0]      live_reg [4];
    logic [31:0]      live_next [4];
    logic [31:0]      met_reg [4];
    logic [31:0]      met_next [4];
    logic [31:0]      rsum_reg, rsum_next, wsum_reg, wsum_next;
    logic             mv_reg, mv_next;

    // Shared saturating incrementer and fold compare
    logic [31:0] inc_a, inc_y;
    logic [31:0] fc, fm, fy;

    // Memory ports
    logic             occ_we;
    logic [SET_W-1:0] occ_addr;
    logic [OCC_W-1:0] occ_wdata, occ_rdata;
    logic             tag_we, cnt_we;
    logic [ENT_W-1:0] ent_addr;
    logic [TAG_W-1:0] tag_rdata;
    logic [63:0]      cnt_wdata, cnt_rdata;

    wst_scan_req_t    sreq;
    wst_scan_rsp_t    srsp;
    logic [WAY_W-1:0] scan_way;

    assign inc_y = (inc_a == MAX32) ? inc_a : inc_a + 32'd1;

    always_comb begin
        fc = live_reg[k_reg];
        fm = met_reg[k_reg];
        if (fm == 32'd0) begin
            fy = fc;
        end else if (mode_reg == MODE_BEST && fc < fm) begin
            fy = fc;
        end else if (mode_reg == MODE_WORST && fc > fm) begin
            fy = fc;
        end else begin
            fy = fm;
        end
    end

    wst_ram #(.WIDTH(OCC_W), .DEPTH(2 ** SET_W)) u_occ_ram (
        .aclk(aclk), .we(occ_we), .addr(occ_addr), .wdata(occ_wdata), .rdata(occ_rdata)
    );
    wst_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
        .aclk(aclk), .we(tag_we), .addr(ent_addr), .wdata(tag_reg), .rdata(tag_rdata)
    );
    wst_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .addr(ent_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
    );

    wst_scan u_scan (
        .aclk(aclk), .aresetn(aresetn), .req(sreq), .tag_rdata(tag_rdata),
        .rd_way(scan_way), .rsp(srsp)
    );

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        set_next   = set_reg;
        tag_next   = tag_reg;
        occ_next   = occ_reg;
        way_next   = way_reg;
        k_next     = k_reg;
        newb_next  = newb_reg;
        full_next  = full_reg;
        on_next    = on_reg;
        blk_next   = blk_reg;
        wide_next  = wide_reg;
        live_next  = live_reg;
        met_next   = met_reg;
        rsum_next  = rsum_reg;
        wsum_next  = wsum_reg;
        mv_next    = mv_reg && !m_ready;
        inc_a      = 32'd0;
        occ_we     = 1'b0;
        occ_addr   = set_reg;
        occ_wdata  = '0;
        tag_we     = 1'b0;
        cnt_we     = 1'b0;
        ent_addr   = {set_reg, scan_way};
        cnt_wdata  = cnt_rdata;
        sreq       = '0;
        case (state_reg)
            ST_CLEAR: begin
                occ_we   = 1'b1;
                set_next = set_reg + SET_W'(1);
                if (set_reg == SET_W'(SET_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next   = s_opcode;
                    set_next  = SET_W'(s_address[OFF_W +: SET_W] & SET_W'(SET_COUNT - 1));
                    tag_next  = s_address[31 -: TAG_W];
                    newb_next = 1'b0;
                    full_next = 1'b0;
                    k_next    = 2'd0;
                    if (s_opcode == OP_LOOP) begin
                        on_next    = 1'b1;
                        state_next = on_reg ? ST_FOLD : ST_OUT;
                    end else if (!on_reg) begin
                        state_next = ST_OUT;
                    end else if (s_opcode == OP_INSTR) begin
                        state_next = ST_OUT;
                        inc_a      = live_reg[0];
                        live_next[0] = inc_y;
                    end else begin
                        occ_addr   = SET_W'(s_address[OFF_W +: SET_W] & SET_W'(SET_COUNT - 1));
                        state_next = ST_OCCWT;
                    end
                end
            end
            ST_OCCWT: begin
                occ_next   = occ_rdata;
                sreq.start = 1'b1;
                sreq.tag   = tag_reg;
                sreq.occ   = occ_rdata;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (srsp.done) begin
                    if (srsp.found) begin
                        way_next   = srsp.way;
                        state_next = ST_RDCNT;
                    end else if (occ_reg >= OCC_W'(WAYS)) begin
                        newb_next  = 1'b1;
                        full_next  = 1'b1;
                        state_next = ST_OCC;
                    end else begin
                        newb_next  = 1'b1;
                        way_next   = occ_reg[WAY_W-1:0];
                        state_next = ST_WRCNT;
                    end
                end
            end
            ST_RDCNT: begin
                ent_addr   = {set_reg, way_reg};
                state_next = ST_WRCNT;
            end
            ST_WRCNT: begin
                ent_addr  = {set_reg, way_reg};
                cnt_we    = 1'b1;
                if (newb_reg) begin
                    tag_we    = 1'b1;
                    cnt_wdata = 64'd0;
                    occ_we    = 1'b1;
                    occ_wdata = occ_reg + OCC_W'(1);
                    if (occ_reg + OCC_W'(1) > wide_reg) begin
                        wide_next = occ_reg + OCC_W'(1);
                    end
                    if (blk_reg != 14'h3FFF) begin
                        blk_next = blk_reg + 14'd1;
                    end
                end
                if (op_reg == OP_WRITE) begin
                    inc_a = newb_reg ? 32'd0 : cnt_rdata[63:32];
                    cnt_wdata[63:32] = inc_y;
                    wsum_next = (wsum_reg == MAX32) ? wsum_reg : wsum_reg + 32'd1;
                end else begin
                    inc_a = newb_reg ? 32'd0 : cnt_rdata[31:0];
                    cnt_wdata[31:0] = inc_y;
                    rsum_next = (rsum_reg == MAX32) ? rsum_reg : rsum_reg + 32'd1;
                end
                state_next = ST_OCC;
            end
            ST_OCC: begin
                // Count the access per loop
                if (op_reg == OP_WRITE) begin
                    live_next[2] = (live_reg[2] == MAX32) ? MAX32 : live_reg[2] + 32'd1;
                end else begin
                    live_next[1] = (live_reg[1] == MAX32) ? MAX32 : live_reg[1] + 32'd1;
                end
                live_next[3] = (live_reg[3] == MAX32) ? MAX32 : live_reg[3] + 32'd1;
                state_next   = ST_OUT;
            end
            ST_FOLD: begin
                met_next[k_reg]  = fy;
                live_next[k_reg] = 32'd0;
                k_next           = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            mode_reg  <= MODE_WORST;
            set_reg   <= '0;
            on_reg    <= 1'b0;
            blk_reg   <= '0;
            wide_reg  <= '0;
            live_reg  <= '{default: 32'd0};
            met_reg   <= '{default: 32'd0};
            rsum_reg  <= '0;
            wsum_reg  <= '0;
            mv_reg    <= 1'b0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            set_reg  <= set_next;
            on_reg   <= on_next;
            blk_reg  <= blk_next;
            wide_reg <= wide_next;
            live_reg <= live_next;
            met_reg  <= met_next;
            rsum_reg <= rsum_next;
            wsum_reg <= wsum_next;
            mv_reg   <= mv_next;
            k_reg    <= k_next;
        end
        op_reg   <= op_next;
        tag_reg  <= tag_next;
        occ_reg  <= occ_next;
        way_reg  <= way_next;
        newb_reg <= newb_next;
        full_reg <= full_next;
    end

    // Result registers: snapshot taken when the item is shown
    logic        rn_reg, rf_reg;
    logic [13:0] rb_reg;
    logic [4:0]  rw_reg;
    logic [31:0] r_reg [6];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!mv_reg || m_ready)) begin
            rn_reg   <= newb_reg;
            rf_reg   <= full_reg;
            rb_reg   <= blk_reg;
            rw_reg   <= (wide_reg > OCC_W'(31)) ? 5'd31 : 5'(wide_reg);
            r_reg[0] <= met_reg[0];
            r_reg[1] <= met_reg[1];
            r_reg[2] <= met_reg[2];
            r_reg[3] <= met_reg[3];
            r_reg[4] <= rsum_reg;
            r_reg[5] <= wsum_reg;
        end
    end

    assign m_valid             = mv_reg;
    assign m_new_block         = rn_reg;
    assign m_set_full          = rf_reg;
    assign m_distinct_blocks   = rb_reg;
    assign m_max_ways_used     = rw_reg;
    assign m_loop_instructions = r_reg[0];
    assign m_loop_reads        = r_reg[1];
    assign m_loop_writes       = r_reg[2];
    assign m_loop_accesses     = r_reg[3];
    assign m_total_reads       = r_reg[4];
    assign m_total_writes      = r_reg[5];

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("second item taken while busy");
    a_full_new: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && full_reg |-> newb_reg) else $error("full without new");
    a_no_ready_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready) else $error("ready during clear");
`endif
endmodule
